// File: src/jsc_pkg.sv
package jsc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_DEGREE = 255;
  localparam int X_FRAC     = 30;
  localparam int SH         = X_FRAC - FRAC_BITS;
  localparam int CFG_W      = 22;
  localparam int OUT_W      = 48;
  localparam int D_W        = 28;   // d0, k1 and their small sums
  localparam int DEN_W      = 40;   // divisor products of the general path

  localparam logic [7:0] KMAX = (MAX_DEGREE > 255) ? 8'd255 : 8'(MAX_DEGREE);

  localparam logic signed [63:0] VLIM    = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] VLIM_X  = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] OMAX_X  = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] OMIN_X  = -OMAX_X - 65'sd1;
  localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO     = ONE <<< 1;
  localparam logic signed [63:0] FOUR    = ONE <<< 2;
  localparam logic signed [D_W-1:0] ONE_D = D_W'(ONE);

  typedef enum logic [0:0] {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_SETUP, S_DENB, S_DENU,
    S_T, S_INNER, S_B, S_U, S_C,
    S_ZB, S_ZC,
    S_MQ, S_MB, S_MC,
    S_MUL1, S_MUL2, S_Y1, S_Y2, S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    MD_IDLE, MD_MUL, MD_CHK, MD_DIV, MD_FIN
  } md_state_t;

  typedef struct packed {
    step_t step;
    logic  load;
    logic  go;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic md_done;
    logic k_zero;
    logic g_zero;
    logic g_mone;
    logic empty;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic              sat;
    logic signed [63:0] val;
  } clamp_t;

  // clamp to +-(2^62-1)
  function automatic clamp_t clamp62(input logic signed [64:0] v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[63:0];
    if (v > VLIM_X) begin
      r.sat = 1'b1;
      r.val = VLIM;
    end else if (v < -VLIM_X) begin
      r.sat = 1'b1;
      r.val = -VLIM;
    end
    return r;
  endfunction

endpackage

// File: src/jsc_in_if.sv
interface jsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_point;
  logic signed [31:0] coeff;
  logic [7:0]         term_index;
  logic               first_term;
  logic               empty_series;

  modport source (output valid, x_point, coeff, term_index, first_term, empty_series,
                  input ready);
  modport sink (input valid, x_point, coeff, term_index, first_term, empty_series,
                output ready);
endinterface

// File: src/jsc_out_if.sv
interface jsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] series_value;
  logic               saturated;

  modport source (output valid, series_value, saturated, input ready);
  modport sink (input valid, series_value, saturated, output ready);
endinterface

// File: src/jsc_muldiv.sv
module jsc_muldiv (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic                mul_only,
  input  logic                sh_en,
  input  logic signed [63:0]  p,
  input  logic signed [63:0]  q,
  input  logic signed [63:0]  d,
  output logic                done,
  output logic                sat,
  output logic signed [63:0]  quo_res,
  output logic signed [127:0] prod_res
);

  jsc_pkg::md_state_t state, state_next;

  logic [63:0]  am, bm, dm, nlo, quo, rem;
  logic [127:0] prod;
  logic [5:0]   cnt;
  logic         neg, shf, mulo, dzero, satf;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh, n_sh;
  logic [64:0]  rem_x, rem_d;
  logic [63:0]  quo_c;
  logic         quo_big;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  always_comb begin
    a_half = cnt[0] ? am[63:32] : am[31:0];
    b_half = cnt[1] ? bm[63:32] : bm[31:0];
    pp     = a_half * b_half;
    unique case (cnt[1:0])
      2'b00:        pp_sh = {64'd0, pp};
      2'b01, 2'b10: pp_sh = {32'd0, pp, 32'd0};
      2'b11:        pp_sh = {pp, 64'd0};
    endcase
    n_sh    = shf ? (prod << jsc_pkg::SH) : prod;
    rem_x   = {rem, nlo[63]};
    rem_d   = rem_x - {1'b0, dm};
    quo_big = quo > 64'(jsc_pkg::VLIM);
    quo_c   = quo_big ? 64'(jsc_pkg::VLIM) : quo;
    quo_res = neg ? -$signed(quo_c) : $signed(quo_c);
    prod_res = neg ? -$signed(prod) : $signed(prod);
    sat     = satf | quo_big;
    done    = (state == jsc_pkg::MD_FIN);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jsc_pkg::MD_IDLE: if (go) state_next = jsc_pkg::MD_MUL;
      jsc_pkg::MD_MUL: begin
        if (cnt[1:0] == 2'b11) state_next = mulo ? jsc_pkg::MD_FIN : jsc_pkg::MD_CHK;
      end
      jsc_pkg::MD_CHK: begin
        if (dzero || (n_sh[127:64] >= dm)) state_next = jsc_pkg::MD_FIN;
        else state_next = jsc_pkg::MD_DIV;
      end
      jsc_pkg::MD_DIV: if (cnt == 6'd63) state_next = jsc_pkg::MD_FIN;
      jsc_pkg::MD_FIN: state_next = jsc_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsc_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      jsc_pkg::MD_IDLE: begin
        if (go) begin
          am    <= mag(p);
          bm    <= mag(q);
          dm    <= mag(d);
          dzero <= (d == 64'sd0);
          neg   <= mul_only ? (p[63] ^ q[63]) : (p[63] ^ q[63] ^ d[63]);
          shf   <= sh_en;
          mulo  <= mul_only;
          prod  <= '0;
          cnt   <= '0;
          quo   <= '0;
          satf  <= 1'b0;
        end
      end
      jsc_pkg::MD_MUL: begin
        prod <= prod + pp_sh;
        cnt  <= cnt + 6'd1;
      end
      jsc_pkg::MD_CHK: begin
        if (dzero) begin
          satf <= 1'b1;
          quo  <= '0;
        end else if (n_sh[127:64] >= dm) begin
          // quotient would not fit
          satf <= 1'b1;
          quo  <= 64'(jsc_pkg::VLIM);
        end else begin
          rem <= n_sh[127:64];
          nlo <= n_sh[63:0];
          cnt <= '0;
        end
      end
      jsc_pkg::MD_DIV: begin
        if (!rem_d[64]) begin
          rem <= rem_d[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_x[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        nlo <= nlo << 1;
        cnt <= cnt + 6'd1;
      end
      jsc_pkg::MD_FIN: ;
    endcase
  end

endmodule

// File: src/jsc_datapath.sv
module jsc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  jsc_pkg::cmd_t               cmd,
  output jsc_pkg::status_t            status,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [jsc_pkg::CFG_W-1:0]   cfg_data,
  input  logic signed [31:0]          x_point,
  input  logic signed [31:0]          coeff,
  input  logic [7:0]                  term_index,
  input  logic                        first_term,
  input  logic                        empty_series,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [jsc_pkg::OUT_W-1:0] series_value,
  output logic                        saturated
);

  logic signed [jsc_pkg::CFG_W-1:0]   alpha, beta;
  logic signed [jsc_pkg::CFG_W:0]     g_val;
  logic signed [31:0]                 x_val, coeff_val;
  logic [7:0]                         k;
  logic                               empty_f;
  logic signed [jsc_pkg::D_W-1:0]     d0, k1;
  logic signed [jsc_pkg::DEN_W-1:0]   denb, denu;
  logic signed [63:0]                 t_val, inner, b_val, c_val, u_val, y1;
  logic signed [127:0]                acc;
  logic signed [jsc_pkg::OUT_W-1:0]   h1, h2, y48;
  logic                               sat;

  logic signed [63:0] a_x, b_x, g_x, x_x, d0_x, k1_x, amb, opa, h1_x, h2_x;
  logic signed [63:0] op_p, op_q, op_d;
  logic               op_sh, op_mul;
  logic               md_done, md_sat;
  logic signed [63:0] md_quo;
  logic signed [127:0] md_prod;

  logic signed [jsc_pkg::D_W-1:0] k_s, kg, kg1;
  logic signed [9:0]              kp1, kp2;
  logic signed [jsc_pkg::D_W+9:0] prod_b, prod_u;
  jsc_pkg::clamp_t                cl_inner, cl_x, cl_acc;
  logic                           acc_fit, y_hi, y_lo, sat_set;
  logic signed [63:0]             y1_next;
  logic signed [64:0]             y_sum;
  logic [7:0]                     k_in;

  assign a_x  = alpha;
  assign b_x  = beta;
  assign g_x  = g_val;
  assign x_x  = x_val;
  assign d0_x = d0;
  assign k1_x = k1;
  assign h1_x = h1;
  assign h2_x = h2;
  assign amb  = a_x - b_x;
  assign opa  = jsc_pkg::ONE + a_x;
  assign k_in = (term_index > jsc_pkg::KMAX) ? jsc_pkg::KMAX : term_index;

  assign k_s    = $signed(jsc_pkg::D_W'(k));
  assign kp1    = $signed(10'(k) + 10'd1);
  assign kp2    = $signed(10'(k) + 10'd2);
  assign kg     = k1 + jsc_pkg::D_W'(g_val);
  assign kg1    = kg + jsc_pkg::ONE_D;
  assign prod_b = kp1 * kg;
  assign prod_u = kp2 * kg1;

  // operand select for the shared multiply/divide unit
  always_comb begin
    op_p   = '0;
    op_q   = '0;
    op_d   = '0;
    op_sh  = 1'b0;
    op_mul = 1'b0;
    unique case (cmd.step)
      jsc_pkg::S_T: begin
        op_p = amb; op_q = g_x; op_sh = 1'b1; op_d = d0_x;
      end
      jsc_pkg::S_INNER: begin
        op_p = d0_x + jsc_pkg::TWO; op_q = x_x; op_d = jsc_pkg::ONE;
      end
      jsc_pkg::S_B: begin
        op_p = d0_x + jsc_pkg::ONE; op_q = inner; op_d = 64'(denb);
      end
      jsc_pkg::S_U: begin
        op_p = k1_x + a_x; op_q = k1_x + b_x; op_sh = 1'b1; op_d = 64'(denu);
      end
      jsc_pkg::S_C: begin
        op_p = u_val; op_q = d0_x + jsc_pkg::FOUR; op_d = d0_x + jsc_pkg::TWO;
      end
      jsc_pkg::S_ZB: begin
        op_p = amb; op_q = 64'sd1; op_sh = 1'b1; op_d = 64'sd2;
      end
      jsc_pkg::S_ZC: begin
        op_p = opa; op_q = jsc_pkg::ONE + b_x; op_sh = 1'b1; op_d = jsc_pkg::TWO;
      end
      jsc_pkg::S_MQ: begin
        op_p = amb; op_q = 64'sd1; op_sh = 1'b1; op_d = 64'sd1;
      end
      jsc_pkg::S_MB: begin
        op_p = inner; op_q = 64'sd1; op_d = 64'sd2;
      end
      jsc_pkg::S_MC: begin
        op_p = opa + (opa <<< 1); op_q = jsc_pkg::ONE + b_x; op_sh = 1'b1;
        op_d = jsc_pkg::TWO;
      end
      jsc_pkg::S_MUL1: begin
        op_p = b_val; op_q = h1_x; op_mul = 1'b1;
      end
      jsc_pkg::S_MUL2: begin
        op_p = c_val; op_q = h2_x; op_mul = 1'b1;
      end
      default: ;
    endcase
  end

  jsc_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.go),
    .mul_only (op_mul),
    .sh_en    (op_sh),
    .p        (op_p),
    .q        (op_q),
    .d        (op_d),
    .done     (md_done),
    .sat      (md_sat),
    .quo_res  (md_quo),
    .prod_res (md_prod)
  );

  always_comb begin
    cl_inner = jsc_pkg::clamp62(65'(md_quo) + 65'(t_val));
    cl_x     = jsc_pkg::clamp62(65'(x_x) + 65'(md_quo));
    // floor by 2^30 fits in 64 bits when the dropped top bits are all sign
    acc_fit  = (&acc[127:93]) | ~(|acc[127:93]);
    cl_acc   = jsc_pkg::clamp62(65'($signed(acc[93:30])));
    y1_next  = acc_fit ? cl_acc.val : (acc[127] ? -jsc_pkg::VLIM : jsc_pkg::VLIM);
    y_sum    = 65'(y1) + 65'(coeff_val);
    y_hi     = y_sum > jsc_pkg::OMAX_X;
    y_lo     = y_sum < jsc_pkg::OMIN_X;

    sat_set = 1'b0;
    if (md_done && !op_mul) begin
      sat_set = md_sat;
      if (cmd.step == jsc_pkg::S_INNER) sat_set = md_sat | cl_inner.sat;
      if (cmd.step == jsc_pkg::S_ZB || cmd.step == jsc_pkg::S_MQ) begin
        sat_set = md_sat | cl_x.sat;
      end
    end
    if (cmd.step == jsc_pkg::S_Y1) sat_set = !acc_fit | cl_acc.sat;
    if (cmd.step == jsc_pkg::S_Y2) sat_set = y_hi | y_lo;
  end

  always_comb begin
    status.md_done  = md_done;
    status.k_zero   = (k == 8'd0);
    status.g_zero   = (g_val == '0);
    status.g_mone   = (g_x == -jsc_pkg::ONE);
    status.empty    = empty_f;
    status.out_busy = out_valid && !out_ready;
  end

  // config, history, sticky flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= '0;
      beta      <= '0;
      h1        <= '0;
      h2        <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (jsc_pkg::cfg_reg_t'(cfg_index))
          jsc_pkg::REG_ALPHA: alpha <= cfg_data;
          jsc_pkg::REG_BETA:  beta  <= cfg_data;
        endcase
      end
      if (cmd.load && (empty_series || first_term)) begin
        h1  <= '0;
        h2  <= '0;
        sat <= 1'b0;
      end else begin
        if (sat_set) sat <= 1'b1;
        if (cmd.step == jsc_pkg::S_Y2) begin
          h2 <= h1;
          h1 <= y_hi ? jsc_pkg::OUT_W'(jsc_pkg::OMAX_X) :
                y_lo ? jsc_pkg::OUT_W'(jsc_pkg::OMIN_X) : y_sum[jsc_pkg::OUT_W-1:0];
        end
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_val     <= x_point;
      coeff_val <= coeff;
      k         <= k_in;
      g_val     <= (jsc_pkg::CFG_W+1)'(alpha) + (jsc_pkg::CFG_W+1)'(beta);
      empty_f   <= empty_series;
      y48       <= '0;
    end
    unique case (cmd.step)
      jsc_pkg::S_SETUP: begin
        d0 <= (k_s <<< (jsc_pkg::FRAC_BITS + 1)) + jsc_pkg::D_W'(g_val);
        k1 <= (k_s + jsc_pkg::D_W'(1)) <<< jsc_pkg::FRAC_BITS;
      end
      jsc_pkg::S_DENB: denb <= jsc_pkg::DEN_W'(prod_b) <<< 1;
      jsc_pkg::S_DENU: denu <= jsc_pkg::DEN_W'(prod_u);
      jsc_pkg::S_T:     if (md_done) t_val <= md_quo;
      jsc_pkg::S_INNER: if (md_done) inner <= cl_inner.val;
      jsc_pkg::S_MQ:    if (md_done) inner <= cl_x.val;
      jsc_pkg::S_ZB:    if (md_done) b_val <= cl_x.val;
      jsc_pkg::S_B, jsc_pkg::S_MB: if (md_done) b_val <= md_quo;
      jsc_pkg::S_U:     if (md_done) u_val <= md_quo;
      jsc_pkg::S_C, jsc_pkg::S_ZC, jsc_pkg::S_MC: if (md_done) c_val <= md_quo;
      jsc_pkg::S_MUL1:  if (md_done) acc <= md_prod;
      jsc_pkg::S_MUL2:  if (md_done) acc <= acc - md_prod;
      jsc_pkg::S_Y1:    y1 <= y1_next;
      jsc_pkg::S_Y2: begin
        y48 <= y_hi ? jsc_pkg::OUT_W'(jsc_pkg::OMAX_X) :
               y_lo ? jsc_pkg::OUT_W'(jsc_pkg::OMIN_X) : y_sum[jsc_pkg::OUT_W-1:0];
      end
      default: ;
    endcase
    if (cmd.emit) begin
      series_value <= y48;
      saturated    <= sat;
    end
  end

endmodule

// File: src/jsc_ctrl.sv
module jsc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  jsc_pkg::status_t status,
  output jsc_pkg::cmd_t    cmd
);

  jsc_pkg::step_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.step   = state;
    cmd.load   = 1'b0;
    cmd.go     = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state)
      jsc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = jsc_pkg::S_DECIDE;
        end
      end
      jsc_pkg::S_DECIDE: state_next = status.empty ? jsc_pkg::S_EMIT : jsc_pkg::S_SETUP;
      jsc_pkg::S_SETUP:  state_next = jsc_pkg::S_DENB;
      jsc_pkg::S_DENB:   state_next = jsc_pkg::S_DENU;
      jsc_pkg::S_DENU: begin
        priority if (status.k_zero && status.g_zero) state_next = jsc_pkg::S_ZB;
        else if (status.k_zero && status.g_mone) state_next = jsc_pkg::S_MQ;
        else state_next = jsc_pkg::S_T;
      end
      jsc_pkg::S_T: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_INNER;
      end
      jsc_pkg::S_INNER: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_B;
      end
      jsc_pkg::S_B: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_U;
      end
      jsc_pkg::S_U: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_C;
      end
      jsc_pkg::S_C: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_MUL1;
      end
      jsc_pkg::S_ZB: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_ZC;
      end
      jsc_pkg::S_ZC: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_MUL1;
      end
      jsc_pkg::S_MQ: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_MB;
      end
      jsc_pkg::S_MB: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_MC;
      end
      jsc_pkg::S_MC: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_MUL1;
      end
      jsc_pkg::S_MUL1: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_MUL2;
      end
      jsc_pkg::S_MUL2: begin
        cmd.go = 1'b1;
        if (status.md_done) state_next = jsc_pkg::S_Y1;
      end
      jsc_pkg::S_Y1: state_next = jsc_pkg::S_Y2;
      jsc_pkg::S_Y2: state_next = status.k_zero ? jsc_pkg::S_EMIT : jsc_pkg::S_IDLE;
      jsc_pkg::S_EMIT: begin
        // wait for the output register to free up
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = jsc_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

// File: src/jacobi_series_clenshaw.sv
// Jacobi series evaluator, Clenshaw backward recurrence, fixed point.
// Config: cfg_we/cfg_index/cfg_data write alpha (index 0) and beta (index 1),
// Q6.16 in 22 bits; write only while the block is idle.
// items: one word per coefficient, highest index first, first_term on the
// top coefficient, empty_series for a series of negative degree.
// results: one word per series, sent after the word with index 0 or an empty_series word.
// Flow: one word at a time. Every multiply-divide step runs on one shared
// unit: 32x32 partial products, a range check, then a restoring division
// to a 64-bit quotient (products skip the check and division; an overflow
// or zero divisor ends the step at the check). A word with index > 0 or a
// general alpha+beta takes 5 of those steps plus 2 products; index 0 takes
// 2 steps with alpha+beta = 0 and 3 with -1, plus the 2 products each.
// The result sits in an output register; a stalled receiver blocks input only
// from the next emission on, later words are accepted and worked on until then.
// Reset clears alpha, beta, the history, the sticky flag and the output valid.
module jacobi_series_clenshaw (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [jsc_pkg::CFG_W-1:0] cfg_data,
  jsc_in_if.sink                    items,
  jsc_out_if.source                 results
);

  jsc_pkg::cmd_t    cmd;
  jsc_pkg::status_t status;
  logic             ready;

  assign items.ready = ready;

  jsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  jsc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .x_point      (items.x_point),
    .coeff        (items.coeff),
    .term_index   (items.term_index),
    .first_term   (items.first_term),
    .empty_series (items.empty_series),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .series_value (results.series_value),
    .saturated    (results.saturated)
  );

endmodule

// File: src/jsc_checker.sv
module jsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] series_value,
  input logic        saturated
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(series_value) && $stable(saturated))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one word in flight: no acceptance in the cycle after one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken back to back");

  // results only appear from the emit step, never straight out of idle
  assert property (@(posedge clk) disable iff (rst)
    in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without work");

endmodule

bind jacobi_series_clenshaw jsc_checker u_jsc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .series_value (results.series_value),
  .saturated    (results.saturated)
);
